// File: design/journal_record_deframer_defines.svh
// ----------------------------------------------------------------------------
// journal_record_deframer_defines.svh
// Assertion macros shared by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef JOURNAL_RECORD_DEFRAMER_DEFINES_SVH
`define JOURNAL_RECORD_DEFRAMER_DEFINES_SVH

// Clocked property, disabled while reset is held.
`define JRD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same-cycle implication, disabled while reset is held.
`define JRD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/jrd_pkg.sv
// ----------------------------------------------------------------------------
// jrd_pkg
// Types, constants and the CRC-32C byte step for the journal record deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package jrd_pkg;

    localparam logic [31:0] REC_MAGIC       = 32'h4A46_5443;
    localparam int unsigned HDR_BYTES       = 28;
    localparam int unsigned CRC_SPAN        = 24;
    localparam int unsigned LABEL_LIMIT_DEF = 64;
    localparam logic [31:0] CRC_POLY        = 32'h82F6_3B78;

    localparam logic [15:0] FORMAT_VERSION_RST = 16'd1;
    localparam logic [31:0] MAX_PAYLOAD_RST    = 32'd16777216;

    localparam int unsigned POS_W     = 33;
    localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TRUNC    = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_VERSION  = 3'd3,
        ST_RESERVED = 3'd4,
        ST_LABEL    = 3'd5,
        ST_PAYLOAD  = 3'd6,
        ST_CRC      = 3'd7
    } status_t;

    // register index decoded from paddr[2]
    typedef enum logic {
        CFG_FORMAT_VERSION = 1'b0,
        CFG_MAX_PAYLOAD    = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] format_version;
        logic [31:0] max_payload_bytes;
    } cfg_t;

    // first member lands in the top bits, so status sits at bit 0 of tdata
    typedef struct packed {
        logic [32:0] record_bytes;
        logic [31:0] payload_length;
        logic [6:0]  label_length;
        logic [63:0] sequence_number;
        status_t     status;
    } out_fields_t;

    localparam int unsigned OUT_FIELDS_W = $bits(out_fields_t);
    localparam int unsigned M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned S_TDATA_W    = 8;

    typedef struct packed {
        logic        emit;
        out_fields_t fields;
    } res_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/jrd_parser.sv
// ----------------------------------------------------------------------------
// jrd_parser
// Per-byte record parse: header capture, checks, CRC and record accounting.
// ----------------------------------------------------------------------------
`default_nettype none

module jrd_parser
    import jrd_pkg::*;
#(
    parameter int unsigned LABEL_LIMIT = LABEL_LIMIT_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_data,
    input  wire cfg_t       cfg,
    output res_t            res
);

    logic [POS_W-1:0] pos_reg, pos_next, pos_inc;
    logic [31:0]      crc_reg, crc_next, crc_upd, crc_cur;
    logic             discard_reg, discard_next;
    logic [POS_W-1:0] total_reg, total_next, total_hdr;
    logic [7:0]       hdr_reg [0:HDR_BYTES-1];

    logic [31:0] magic, pay, crc_hdr;
    logic [15:0] ver, lab;
    logic [63:0] seq;
    logic [7:0]  byte27;
    logic        rsv_nz, crc_en, crc_ok, at_last_hdr;
    status_t     hdr_st;

    assign at_last_hdr = (pos_reg == POS_W'(HDR_BYTES - 1));
    assign byte27      = at_last_hdr ? data_byte : hdr_reg[HDR_BYTES-1];

    assign magic   = {hdr_reg[0], hdr_reg[1], hdr_reg[2], hdr_reg[3]};
    assign ver     = {hdr_reg[4], hdr_reg[5]};
    assign rsv_nz  = |(hdr_reg[6] | hdr_reg[7] | hdr_reg[22] | hdr_reg[23]);
    assign seq     = {hdr_reg[8],  hdr_reg[9],  hdr_reg[10], hdr_reg[11],
                      hdr_reg[12], hdr_reg[13], hdr_reg[14], hdr_reg[15]};
    assign pay     = {hdr_reg[16], hdr_reg[17], hdr_reg[18], hdr_reg[19]};
    assign lab     = {hdr_reg[20], hdr_reg[21]};
    assign crc_hdr = {hdr_reg[24], hdr_reg[25], hdr_reg[26], byte27};

    assign total_hdr = POS_W'(HDR_BYTES) + POS_W'(lab) + POS_W'(pay);
    assign pos_inc   = pos_reg + POS_W'(1);

    // CRC skips the stored CRC field itself
    assign crc_en  = (pos_reg < POS_W'(CRC_SPAN)) || (pos_reg >= POS_W'(HDR_BYTES));
    assign crc_upd = crc_byte(crc_reg, data_byte);
    assign crc_cur = crc_en ? crc_upd : crc_reg;
    assign crc_ok  = ((crc_cur ^ 32'hFFFF_FFFF) == crc_hdr);

    always_comb begin
        if (magic != REC_MAGIC) begin
            hdr_st = ST_MAGIC;
        end else if (ver != cfg.format_version) begin
            hdr_st = ST_VERSION;
        end else if (rsv_nz) begin
            hdr_st = ST_RESERVED;
        end else if (lab > 16'(LABEL_LIMIT)) begin
            hdr_st = ST_LABEL;
        end else if (pay > cfg.max_payload_bytes) begin
            hdr_st = ST_PAYLOAD;
        end else begin
            hdr_st = ST_OK;
        end
    end

    always_comb begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        discard_next = discard_reg;
        total_next   = total_reg;
        res          = '0;
        if (step) begin
            if (discard_reg) begin
                if (end_of_data) begin
                    discard_next = 1'b0;
                    pos_next     = '0;
                    crc_next     = '1;
                end
            end else begin
                pos_next = pos_inc;
                crc_next = crc_cur;
                if (pos_reg < POS_W'(HDR_BYTES - 1)) begin
                    if (end_of_data) begin
                        res.emit          = 1'b1;
                        res.fields.status = ST_TRUNC;
                        pos_next          = '0;
                        crc_next          = '1;
                    end
                end else if (at_last_hdr) begin
                    total_next = total_hdr;
                    if (hdr_st != ST_OK) begin
                        res.emit          = 1'b1;
                        res.fields.status = hdr_st;
                        pos_next          = '0;
                        crc_next          = '1;
                        discard_next      = !end_of_data;
                    end else if (total_hdr == POS_W'(HDR_BYTES)) begin
                        // empty body: record ends on the last header byte
                        res.emit                   = 1'b1;
                        res.fields.status          = crc_ok ? ST_OK : ST_CRC;
                        res.fields.sequence_number = seq;
                        res.fields.label_length    = lab[6:0];
                        res.fields.payload_length  = pay;
                        res.fields.record_bytes    = crc_ok ? total_hdr : '0;
                        pos_next                   = '0;
                        crc_next                   = '1;
                    end else if (end_of_data) begin
                        res.emit          = 1'b1;
                        res.fields.status = ST_TRUNC;
                        pos_next          = '0;
                        crc_next          = '1;
                    end
                end else begin
                    if (pos_inc == total_reg) begin
                        res.emit                   = 1'b1;
                        res.fields.status          = crc_ok ? ST_OK : ST_CRC;
                        res.fields.sequence_number = seq;
                        res.fields.label_length    = lab[6:0];
                        res.fields.payload_length  = pay;
                        res.fields.record_bytes    = crc_ok ? total_reg : '0;
                        pos_next                   = '0;
                        crc_next                   = '1;
                    end else if (end_of_data) begin
                        res.emit          = 1'b1;
                        res.fields.status = ST_TRUNC;
                        pos_next          = '0;
                        crc_next          = '1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            crc_reg     <= '1;
            discard_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            discard_reg <= discard_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= total_next;
        if (step && !discard_reg && (pos_reg < POS_W'(HDR_BYTES))) begin
            hdr_reg[pos_reg[HDR_IDX_W-1:0]] <= data_byte;
        end
    end

endmodule

`default_nettype wire

// File: design/journal_record_deframer.sv
// Journal record deframer: takes one buffer byte per clock while the result
// register is free or draining, and checks framed records (28-byte big-endian
// header, label, payload, CRC-32C). The byte is held in the input register; a
// result for a byte that ends a record, fails its header or truncates it is
// registered in the result register when that byte moves on, the path being
// the byte-wide CRC-32C step between the two. A header fault drops bytes up to
// the end-of-buffer mark. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// journal_record_deframer
// Top level: stream input/output registers, APB registers and the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module journal_record_deframer
    import jrd_pkg::*;
#(
    parameter int unsigned LABEL_LIMIT = LABEL_LIMIT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // APB configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // byte stream in
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic                 s_tlast,   // end_of_data
    // record results out
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [2:0] status, [66:3] sequence_number, [73:67] label_length,
    // [105:74] payload_length, [138:106] record_bytes, rest zero
    output logic [M_TDATA_W-1:0]      m_tdata
);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        m_tvalid_reg;
    out_fields_t out_reg;
    logic        advance, s_accept, cfg_wr;
    res_t        res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx_t'(paddr[2]))
            CFG_FORMAT_VERSION: prdata = {16'd0, cfg_reg.format_version};
            CFG_MAX_PAYLOAD:    prdata = cfg_reg.max_payload_bytes;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.format_version    <= FORMAT_VERSION_RST;
            cfg_reg.max_payload_bytes <= MAX_PAYLOAD_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx_t'(paddr[2]))
                CFG_FORMAT_VERSION: cfg_reg.format_version    <= pwdata[15:0];
                CFG_MAX_PAYLOAD:    cfg_reg.max_payload_bytes <= pwdata;
                default:            ;
            endcase
        end
    end

    // byte moves on once the result register is free or being drained
    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata[7:0];
            in_last_reg <= s_tlast;
        end
    end

    jrd_parser #(
        .LABEL_LIMIT (LABEL_LIMIT)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .data_byte   (in_byte_reg),
        .end_of_data (in_last_reg),
        .cfg         (cfg_reg),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= res.emit;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.emit) begin
            out_reg <= res.fields;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - OUT_FIELDS_W)'(0), out_reg};

endmodule

`default_nettype wire

// File: design/jrd_checker.sv
// ----------------------------------------------------------------------------
// jrd_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "journal_record_deframer_defines.svh"

module jrd_checker
    import jrd_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    out_fields_t f;
    logic        hdr_fault;

    assign f         = out_fields_t'(m_tdata[OUT_FIELDS_W-1:0]);
    assign hdr_fault = (f.status != ST_OK) && (f.status != ST_CRC);

    `JRD_ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    `JRD_ASSERT_IMPL(a_fault_zero, aclk, aresetn, m_tvalid && hdr_fault, f.sequence_number == 64'd0 && f.label_length == 7'd0 && f.payload_length == 32'd0 && f.record_bytes == 33'd0, "fault result carries record fields")

    `JRD_ASSERT_IMPL(a_crc_zero, aclk, aresetn, m_tvalid && f.status == ST_CRC, f.record_bytes == 33'd0, "crc mismatch with nonzero byte count")

    `JRD_ASSERT_IMPL(a_ok_count, aclk, aresetn, m_tvalid && f.status == ST_OK, f.record_bytes == 33'(HDR_BYTES) + 33'(f.label_length) + 33'(f.payload_length), "record byte count disagrees with header lengths")

endmodule

bind journal_record_deframer jrd_checker u_jrd_checker (.*);

`default_nettype wire

// File: tb/journal_record_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// journal_record_deframer_tb
// Self-checking bench for the journal record deframer. Builds byte buffers
// of framed records (good, CRC-corrupted, cut short, header faults, noise),
// streams them in with random gaps and output stalls, predicts each record
// result with an independent parser model and compares every field. Runs
// through four register settings, written over APB while the block is idle.
// ----------------------------------------------------------------------------

module journal_record_deframer_tb;
    import jrd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] sequence_number;
        logic [6:0]  label_length;
        logic [31:0] payload_length;
        logic [32:0] record_bytes;
    } record_result_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] ver;
        logic [31:0] rsvd;   // header bytes 6, 7, 22, 23 from the top down
        logic [63:0] seq;
        logic [15:0] lab;
        logic [31:0] pay;
    } record_header_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [2:0]           paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [7:0] data_byte
    logic                 s_tlast  = 1'b0; // end_of_data
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    // [2:0] status, [66:3] sequence_number, [73:67] label_length,
    // [105:74] payload_length, [138:106] record_bytes
    logic [M_TDATA_W-1:0] m_tdata;

    journal_record_deframer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // register copies, parser state and bookkeeping
    logic [15:0]    cfg_version     = FORMAT_VERSION_RST;
    logic [31:0]    cfg_max_payload = MAX_PAYLOAD_RST;
    logic [32:0]    rec_pos         = '0;
    logic [7:0]     hdr_bytes [HDR_BYTES];
    logic [31:0]    crc_run         = '1;
    logic           discarding      = 1'b0;

    stream_byte_t   outgoing_bytes [$];
    record_result_t expected_records [$];

    int  bytes_queued    = 0;
    int  records_made    = 0;
    bit  last_marked     = 1'b0;
    int  bytes_in        = 0;
    int  results_checked = 0;
    int  mismatches      = 0;
    int  settings_run    = 0;
    int  status_seen [8] = '{default: 0};
    int  cycle_count     = 0;

    // -------- CRC-32C, bit-serial form --------
    function automatic logic [31:0] crc32c_update(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // -------- parser prediction --------
    function automatic void expect_record(input status_t st, input logic [63:0] seq,
                                          input logic [15:0] lab, input logic [31:0] pay,
                                          input logic [33:0] used);
        record_result_t r;
        r.status          = st;
        r.sequence_number = seq;
        r.label_length    = lab[6:0];
        r.payload_length  = pay;
        r.record_bytes    = used[32:0];
        expected_records.insert(expected_records.size(), r);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic last);
        logic [33:0] next_pos;
        logic [33:0] total;
        logic [15:0] lab;
        logic [31:0] pay;
        logic [63:0] seq;
        status_t     st;
        if (discarding) begin
            if (last) begin
                discarding = 1'b0;
                rec_pos    = '0;
                crc_run    = '1;
            end
            return;
        end
        if (rec_pos < HDR_BYTES)
            hdr_bytes[rec_pos] = b;
        if (rec_pos < CRC_SPAN || rec_pos >= HDR_BYTES)
            crc_run = crc32c_update(crc_run, b);
        next_pos = {1'b0, rec_pos} + 34'd1;
        rec_pos  = next_pos[32:0];

        if (next_pos < HDR_BYTES) begin
            if (last) begin
                rec_pos = '0;
                crc_run = '1;
                expect_record(ST_TRUNC, '0, '0, '0, '0);
            end
            return;
        end

        lab   = {hdr_bytes[20], hdr_bytes[21]};
        pay   = {hdr_bytes[16], hdr_bytes[17], hdr_bytes[18], hdr_bytes[19]};
        total = 34'(HDR_BYTES) + 34'(lab) + 34'(pay);

        if (next_pos == HDR_BYTES) begin
            st = ST_OK;
            if ({hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]} != REC_MAGIC)
                st = ST_MAGIC;
            else if ({hdr_bytes[4], hdr_bytes[5]} != cfg_version)
                st = ST_VERSION;
            else if ((hdr_bytes[6] | hdr_bytes[7] | hdr_bytes[22] | hdr_bytes[23]) != 8'h00)
                st = ST_RESERVED;
            else if (lab > 16'(LABEL_LIMIT_DEF))
                st = ST_LABEL;
            else if (pay > cfg_max_payload)
                st = ST_PAYLOAD;
            if (st != ST_OK) begin
                rec_pos    = '0;
                crc_run    = '1;
                discarding = !last;
                expect_record(st, '0, '0, '0, '0);
                return;
            end
        end

        if (next_pos >= total) begin
            seq = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11],
                   hdr_bytes[12], hdr_bytes[13], hdr_bytes[14], hdr_bytes[15]};
            if ((crc_run ^ 32'hFFFF_FFFF) !=
                {hdr_bytes[24], hdr_bytes[25], hdr_bytes[26], hdr_bytes[27]})
                expect_record(ST_CRC, seq, lab, pay, '0);
            else
                expect_record(ST_OK, seq, lab, pay, total);
            rec_pos = '0;
            crc_run = '1;
            return;
        end

        if (last) begin
            rec_pos = '0;
            crc_run = '1;
            expect_record(ST_TRUNC, '0, '0, '0, '0);
        end
    endfunction

    // -------- result checking --------
    task automatic check_result(input logic [M_TDATA_W-1:0] word);
        record_result_t got;
        record_result_t want;
        got.status          = status_t'(word[2:0]);
        got.sequence_number = word[66:3];
        got.label_length    = word[73:67];
        got.payload_length  = word[105:74];
        got.record_bytes    = word[138:106];
        results_checked++;
        status_seen[got.status]++;
        if (expected_records.size() == 0) begin
            $error("result with nothing expected: status %0d", got.status);
            mismatches++;
            return;
        end
        want = expected_records.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.sequence_number !== want.sequence_number) begin
            $error("sequence_number: expected %h, got %h",
                   want.sequence_number, got.sequence_number);
            mismatches++;
        end
        if (got.label_length !== want.label_length) begin
            $error("label_length: expected %0d, got %0d", want.label_length, got.label_length);
            mismatches++;
        end
        if (got.payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, got %0d",
                   want.payload_length, got.payload_length);
            mismatches++;
        end
        if (got.record_bytes !== want.record_bytes) begin
            $error("record_bytes: expected %0d, got %0d",
                   want.record_bytes, got.record_bytes);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata[7:0], s_tlast);
                bytes_in++;
            end
        end
    end

    // -------- gaps and stalls --------
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 4);
        return $urandom_range(12, 48);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    int           tx_gap      = 0;
    int           tx_idle_pct = 10;
    int           tx_launches = 0;
    stream_byte_t tx_item;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_gap != 0) begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (outgoing_bytes.size() != 0) begin
                tx_item     = outgoing_bytes.pop_front();
                s_tdata    <= tx_item.data;
                s_tlast    <= tx_item.last;
                s_tvalid   <= 1'b1;
                tx_gap     <= pick_gap(tx_idle_pct);
                tx_launches <= tx_launches + 1;
                if (tx_launches % 100 == 99)
                    tx_idle_pct <= pick_idle_pct();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    int rx_stall    = 0;
    int rx_idle_pct = 5;
    int rx_cycles   = 0;

    always @(posedge aclk) begin
        rx_cycles <= rx_cycles + 1;
        if (rx_cycles % 256 == 255)
            rx_idle_pct <= pick_idle_pct() / 2;
        if (!aresetn) begin
            m_tready <= 1'b1;
            rx_stall <= 0;
        end else if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < rx_idle_pct)
                rx_stall <= pick_gap(100);
        end
    end

    // -------- APB access: write, then read back --------
    task automatic apb_write(input cfg_idx_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == CFG_FORMAT_VERSION)
            cfg_version = value[15:0];
        else
            cfg_max_payload = value;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (idx == CFG_FORMAT_VERSION && prdata[15:0] !== value[15:0]) begin
            $error("format_version readback: expected %h, got %h", value[15:0], prdata[15:0]);
            mismatches++;
        end
        if (idx == CFG_MAX_PAYLOAD && prdata !== value) begin
            $error("max_payload_bytes readback: expected %h, got %h", value, prdata);
            mismatches++;
        end
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // -------- stimulus building --------
    task automatic push_byte(input logic [7:0] data, input logic last);
        stream_byte_t sb;
        sb.data = data;
        sb.last = last;
        outgoing_bytes.insert(outgoing_bytes.size(), sb);
        bytes_queued++;
        last_marked = last;
    endtask

    task automatic put_noise(input int n);
        for (int i = 0; i < n; i++)
            push_byte($urandom, (i == n - 1) || ($urandom_range(0, 5) == 0));
    endtask

    function automatic record_header_t make_header(input logic [15:0] lab,
                                                   input logic [31:0] pay);
        record_header_t hd;
        hd.magic = REC_MAGIC;
        hd.ver   = cfg_version;
        hd.rsvd  = '0;
        hd.seq   = {$urandom, $urandom};
        hd.lab   = lab;
        hd.pay   = pay;
        return hd;
    endfunction

    // cut > 0 sends only the first cut bytes; mark_end tags the final byte sent
    task automatic put_record(input record_header_t hd, input bit bad_crc,
                              input int cut, input bit mark_end);
        logic [7:0]      h [HDR_BYTES];
        logic [7:0]      body [$];
        logic [31:0]     acc;
        longint unsigned full;
        int              n;
        full = 64'(HDR_BYTES) + 64'(hd.lab) + 64'(hd.pay);
        n    = (cut > 0) ? cut : int'(full);
        {h[0], h[1], h[2], h[3]} = hd.magic;
        {h[4], h[5]}             = hd.ver;
        {h[6], h[7], h[22], h[23]} = hd.rsvd;
        {h[8], h[9], h[10], h[11], h[12], h[13], h[14], h[15]} = hd.seq;
        {h[16], h[17], h[18], h[19]} = hd.pay;
        {h[20], h[21]}           = hd.lab;
        for (int i = HDR_BYTES; i < n; i++)
            body.insert(body.size(), 8'($urandom));
        acc = '1;
        for (int i = 0; i < CRC_SPAN; i++)
            acc = crc32c_update(acc, h[i]);
        foreach (body[i])
            acc = crc32c_update(acc, body[i]);
        acc = acc ^ 32'hFFFF_FFFF;
        if (bad_crc)
            acc = acc ^ (32'h1 << $urandom_range(0, 31));
        {h[24], h[25], h[26], h[27]} = acc;
        for (int i = 0; i < n; i++)
            push_byte((i < HDR_BYTES) ? h[i] : body[i - HDR_BYTES], mark_end && (i == n - 1));
    endtask

    // one buffer: a few records, mostly well formed; faults end the buffer
    task automatic random_buffer();
        record_header_t  hd;
        int              nrec;
        int              kind;
        int              maxcut;
        bit              mark;
        logic [31:0]     pay_hi;
        logic [31:0]     span;
        longint unsigned full;
        nrec = $urandom_range(1, 3);
        for (int r = 0; r < nrec; r++) begin
            kind   = $urandom_range(0, 99);
            pay_hi = (cfg_max_payload < 24) ? cfg_max_payload : 32'd24;
            hd = make_header(($urandom_range(0, 7) == 0) ? $urandom_range(0, 64)
                                                         : $urandom_range(0, 6),
                             $urandom_range(0, pay_hi));
            if (kind < 68) begin
                put_record(hd, kind >= 60, 0, (r == nrec - 1) && ($urandom_range(0, 3) != 0));
                records_made++;
            end else if (kind < 76) begin
                if ($urandom_range(0, 3) == 0)
                    hd.pay = $urandom_range(0, cfg_max_payload);
                full   = 64'(HDR_BYTES) + 64'(hd.lab) + 64'(hd.pay);
                maxcut = (full - 1 < 60) ? int'(full - 1) : 60;
                put_record(hd, 1'b0, $urandom_range(1, maxcut), 1'b1);
                records_made++;
                return;
            end else if (kind < 96) begin
                if (kind < 80) begin
                    hd.magic = $urandom;
                    if (hd.magic == REC_MAGIC)
                        hd.magic[0] = ~hd.magic[0];
                    hd.ver = $urandom;
                end else if (kind < 84) begin
                    hd.ver = cfg_version ^ 16'($urandom_range(1, 65535));
                end else if (kind < 88) begin
                    hd.rsvd = ($urandom_range(0, 1) == 0) ? (32'h1 << $urandom_range(0, 31))
                                                          : $urandom;
                    if (hd.rsvd == 0)
                        hd.rsvd = 32'h0100_0000;
                end else if (kind >= 92 && cfg_max_payload != 32'hFFFF_FFFF) begin
                    span   = 32'hFFFF_FFFF - cfg_max_payload;
                    hd.pay = cfg_max_payload + 32'd1 + ($urandom % span);
                end else begin
                    hd.lab = $urandom_range(65, 65535);
                end
                mark = ($urandom_range(0, 2) == 0);
                put_record(hd, 1'b0, HDR_BYTES, mark);
                records_made++;
                if (!mark)
                    put_noise($urandom_range(1, 6));
                return;
            end else begin
                put_noise($urandom_range(1, 12));
                return;
            end
        end
    endtask

    task automatic random_traffic(input int byte_goal, input int record_goal);
        int byte_start;
        int rec_start;
        byte_start = bytes_queued;
        rec_start  = records_made;
        while (bytes_queued - byte_start < byte_goal || records_made - rec_start < record_goal)
            random_buffer();
        // leave the parser idle before any register write
        if (!last_marked)
            push_byte($urandom, 1'b1);
    endtask

    // hold off until all bytes are in and all results are out
    task automatic drain();
        while (outgoing_bytes.size() != 0 || s_tvalid || expected_records.size() != 0)
            @(negedge aclk);
        repeat (16) @(negedge aclk);
        settings_run++;
    endtask

    // -------- run control --------
    initial begin
        record_header_t hd;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values of both registers
        push_byte(8'hFF, 1'b1);                 // end mark on a lone first byte
        put_record(make_header(0, 0), 1'b0, 0, 1'b0);   // empty body, no end mark
        hd = make_header(64, 5);
        hd.seq = '1;
        put_record(hd, 1'b0, 0, 1'b1);
        hd = make_header(3, 0);
        hd.seq = '0;
        put_record(hd, 1'b1, 0, 1'b0);          // CRC mismatch, parsing carries on
        put_record(make_header(0, 7), 1'b0, 0, 1'b1);
        hd = make_header(0, 0);
        hd.magic = '0;
        hd.ver   = 16'hFFFF;                    // magic wins over version
        put_record(hd, 1'b0, HDR_BYTES, 1'b1);  // end mark on the faulting byte
        hd = make_header(2, 2);
        hd.ver = 16'h0000;
        put_record(hd, 1'b0, HDR_BYTES, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h4A, 1'b1);                 // discarded up to here
        for (int k = 0; k < 4; k++) begin
            hd = make_header(0, 1);
            hd.rsvd = 32'h80 << (8 * k);
            if (k == 3)
                hd.lab = 16'd65;                // reserved wins over label
            put_record(hd, 1'b0, HDR_BYTES, 1'b1);
        end
        hd = make_header(0, 0);
        hd.lab = 16'd65;
        hd.pay = 32'hFFFF_FFFF;
        put_record(hd, 1'b0, HDR_BYTES, 1'b1);
        put_record(make_header(0, 32'd16777217), 1'b0, HDR_BYTES, 1'b1);
        put_record(make_header(64, 32'd16777216), 1'b0, 40, 1'b1);  // cut in the body
        put_record(make_header(1, 1), 1'b0, 27, 1'b1);              // cut in the header
        put_record(make_header(0, 3), 1'b0, 0, 1'b1);
        random_traffic(50, 1);
        drain();

        apb_write(CFG_FORMAT_VERSION, 32'h0000_FFFF);
        apb_write(CFG_MAX_PAYLOAD, 32'h0);
        put_record(make_header(0, 0), 1'b0, 0, 1'b1);
        put_record(make_header(2, 0), 1'b0, 0, 1'b0);
        put_record(make_header(0, 1), 1'b0, HDR_BYTES, 1'b1);
        random_traffic(50, 1);
        drain();

        apb_write(CFG_FORMAT_VERSION, 32'h0);
        apb_write(CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
        put_record(make_header(0, 32'hFFFF_FFFF), 1'b0, 35, 1'b1);
        hd = make_header(0, 0);
        hd.lab = 16'hFFFF;
        put_record(hd, 1'b0, HDR_BYTES, 1'b1);
        put_record(make_header(5, 9), 1'b0, 0, 1'b1);
        random_traffic(50, 1);
        drain();

        apb_write(CFG_FORMAT_VERSION, $urandom_range(0, 65535));
        apb_write(CFG_MAX_PAYLOAD, $urandom_range(0, 48));
        random_traffic(60, 2);
        drain();

        if (expected_records.size() != 0) begin
            $error("%0d results never arrived", expected_records.size());
            mismatches++;
        end
        $display("%0d bytes in over %0d register settings, %0d results checked",
                 bytes_in, settings_run, results_checked);
        $display("ok %0d, crc %0d, truncated %0d, header faults %0d",
                 status_seen[ST_OK], status_seen[ST_CRC], status_seen[ST_TRUNC],
                 results_checked - status_seen[ST_OK] - status_seen[ST_CRC]
                     - status_seen[ST_TRUNC]);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $error("run stopped after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
